// File: hw/rtl/lprq_pkg.sv
// ----------------------------------------------------------------------------
// lprq_pkg
// Sizes, codes and field widths shared by the packet ring queue and its
// channel interfaces.
// ----------------------------------------------------------------------------
package lprq_pkg;

  // Ring geometry and record layout
  localparam int BUF_BYTES   = 128;
  localparam int MAX_PAYLOAD = 20;
  localparam int HDR_BYTES   = 4;

  localparam int PTR_W  = $clog2(BUF_BYTES);
  localparam int FREE_W = $clog2(BUF_BYTES + 1);
  localparam int CNT_W  = $clog2(MAX_PAYLOAD + HDR_BYTES + 1);

  // Field widths
  localparam int ACT_W    = 2;
  localparam int LINK_W   = 8;
  localparam int HANDLE_W = 16;
  localparam int LEN_W    = 5;
  localparam int BYTE_W   = 8;
  localparam int STAT_W   = 2;

  // Input actions
  localparam logic [ACT_W-1:0] ACT_HEADER = 2'd0;
  localparam logic [ACT_W-1:0] ACT_BYTE   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_POP    = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_REJECT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_DATA   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd3;

endpackage

// File: hw/rtl/lprq_req_if.sv
// ----------------------------------------------------------------------------
// lprq_req_if
// Request channel: header, payload byte and pop words with valid/ready.
// ----------------------------------------------------------------------------
interface lprq_req_if;
  import lprq_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACT_W-1:0]    action;
  logic [LINK_W-1:0]   link_id;
  logic [HANDLE_W-1:0] attr_handle;
  logic [LEN_W-1:0]    payload_length;
  logic [BYTE_W-1:0]   payload_byte;

  modport source (
    output valid, action, link_id, attr_handle, payload_length, payload_byte,
    input  ready
  );
  modport sink (
    input  valid, action, link_id, attr_handle, payload_length, payload_byte,
    output ready
  );
endinterface

// File: hw/rtl/lprq_rsp_if.sv
// ----------------------------------------------------------------------------
// lprq_rsp_if
// Response channel: status and popped packet data words with valid/ready.
// ----------------------------------------------------------------------------
interface lprq_rsp_if;
  import lprq_pkg::*;

  logic                valid;
  logic                ready;
  logic [STAT_W-1:0]   status;
  logic [LINK_W-1:0]   out_link_id;
  logic [HANDLE_W-1:0] out_handle;
  logic [LEN_W-1:0]    out_length;
  logic [BYTE_W-1:0]   out_byte;
  logic                byte_valid;
  logic                last;

  modport source (
    output valid, status, out_link_id, out_handle, out_length, out_byte,
    output byte_valid, last,
    input  ready
  );
  modport sink (
    input  valid, status, out_link_id, out_handle, out_length, out_byte,
    input  byte_valid, last,
    output ready
  );
endinterface

// File: hw/rtl/length_prefixed_packet_ring_queue_core.sv
// ----------------------------------------------------------------------------
// length_prefixed_packet_ring_queue_core
// Byte ring of length-prefixed radio packet records with header, payload
// byte and pop words in, status and packet data words out.
// ----------------------------------------------------------------------------
// A header's status word is valid the cycle after the header is taken; the
//   header then holds the request side in S_HDR while its other three header
//   bytes are written (one ring write port). A payload byte gives no word.
// A pop holds the request side in S_POP: four header reads, then one byte
//   per cycle while the response side does not stall (one read port).
// Reset: rst clears pointers, counters, free count and sequencer; ring not cleared.
// ----------------------------------------------------------------------------
module length_prefixed_packet_ring_queue_core (
  input  logic        clk,
  input  logic        rst,
  lprq_req_if.sink    req,
  lprq_rsp_if.source  rsp
);
  import lprq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_HDR  = 3'b010,
    S_POP  = 3'b100
  } state_t;

  localparam int SUM_W = FREE_W + 2;

  // Ring storage, one write port and one registered read port
  logic [BYTE_W-1:0] ring [BUF_BYTES];

  state_t            state;
  logic [PTR_W-1:0]  wp, rp, rs;
  logic [FREE_W-1:0] free_cnt;
  logic [7:0]        pkt_cnt;
  logic [LEN_W-1:0]  pending;

  // Header being written
  logic [1:0]          hcnt;
  logic [LINK_W-1:0]   hdr_link;
  logic [HANDLE_W-1:0] hdr_handle;

  // Pop sequencer
  logic [CNT_W-1:0]  rcnt, dcnt;
  logic              pend;
  logic [BYTE_W-1:0] rdata;
  logic [LEN_W-1:0]  pop_len;
  logic [LINK_W-1:0] pop_link;
  logic [7:0]        pop_hi, pop_lo;

  // Output register
  logic                ovalid;
  logic [STAT_W-1:0]   o_status;
  logic [LINK_W-1:0]   o_link;
  logic [HANDLE_W-1:0] o_handle;
  logic [LEN_W-1:0]    o_len;
  logic [BYTE_W-1:0]   o_byte;
  logic                o_bvalid, o_last;

  logic slot_free, accept;
  logic is_hdr, is_byte, is_pop;

  // Header decision
  logic              abandon, reject;
  logic [SUM_W-1:0]  rec_span, free_sum;
  logic [FREE_W-1:0] free_eff;
  logic [PTR_W-1:0]  wp_eff;
  logic [5:0]        rec_bytes;

  // Ring write port
  logic              we;
  logic [PTR_W-1:0]  waddr;
  logic [BYTE_W-1:0] wdata;

  // Pop stepping
  logic             more, issue, move, pop_out, pop_done;
  logic [CNT_W-1:0] pay_idx;
  logic [LEN_W-1:0] byte0_len;
  logic [SUM_W-1:0] pop_free_sum;

  logic                load;
  logic [STAT_W-1:0]   l_status;
  logic [LINK_W-1:0]   l_link;
  logic [HANDLE_W-1:0] l_handle;
  logic [LEN_W-1:0]    l_len;
  logic [BYTE_W-1:0]   l_byte;
  logic                l_bvalid;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(BUF_BYTES - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  // Payload length from a stored length byte, clamped to the legal range
  function automatic logic [LEN_W-1:0] len_of(input logic [BYTE_W-1:0] s);
    logic [BYTE_W-1:0] l;
    l = (s >= BYTE_W'(HDR_BYTES)) ? s - BYTE_W'(HDR_BYTES) : '0;
    if (l > BYTE_W'(MAX_PAYLOAD)) begin
      l = BYTE_W'(MAX_PAYLOAD);
    end
    return l[LEN_W-1:0];
  endfunction

  assign slot_free = !ovalid || rsp.ready;
  assign req.ready = (state == S_IDLE) && slot_free;
  assign accept    = req.valid && req.ready;
  assign is_hdr    = accept && (req.action == ACT_HEADER);
  assign is_byte   = accept && (req.action == ACT_BYTE);
  assign is_pop    = accept && (req.action == ACT_POP);

  // Abandon an open record first: return its space, rewind the write pointer
  always_comb begin
    abandon  = (pending != '0);
    rec_span = (wp >= rs) ? SUM_W'(wp) - SUM_W'(rs)
                          : SUM_W'(wp) + SUM_W'(BUF_BYTES) - SUM_W'(rs);
    free_sum = SUM_W'(free_cnt) + rec_span + SUM_W'(pending);
    if (!abandon) begin
      free_eff = free_cnt;
    end else if (free_sum > SUM_W'(BUF_BYTES)) begin
      free_eff = FREE_W'(BUF_BYTES);
    end else begin
      free_eff = free_sum[FREE_W-1:0];
    end
    wp_eff    = abandon ? rs : wp;
    rec_bytes = 6'(req.payload_length) + 6'(HDR_BYTES);
    reject    = (req.payload_length > LEN_W'(MAX_PAYLOAD))
             || (SUM_W'(free_eff) < SUM_W'(rec_bytes));
  end

  // Ring write port: length byte at accept, then three header bytes, or a
  // payload byte
  always_comb begin
    we    = 1'b0;
    waddr = wp;
    wdata = req.payload_byte;
    if (is_hdr && !reject) begin
      we    = 1'b1;
      waddr = wp_eff;
      wdata = BYTE_W'(rec_bytes);
    end else if (is_byte && abandon) begin
      we = 1'b1;
    end else if (state == S_HDR) begin
      we = 1'b1;
      case (hcnt)
        2'd1:    wdata = hdr_link;
        2'd2:    wdata = hdr_handle[15:8];
        default: wdata = hdr_handle[7:0];
      endcase
    end
  end

  // Pop: issue reads ahead while the data register drains into the output
  always_comb begin
    pay_idx  = dcnt - CNT_W'(HDR_BYTES);
    more     = (rcnt < CNT_W'(HDR_BYTES))
            || ((rcnt - CNT_W'(HDR_BYTES)) < CNT_W'(pop_len));
    pop_out  = (dcnt >= CNT_W'(HDR_BYTES))
            || ((dcnt == CNT_W'(HDR_BYTES - 1)) && (pop_len == '0));
    move     = pend && (!pop_out || slot_free);
    issue    = (state == S_POP) && more && (!pend || move);
    pop_done = move && pop_out
            && ((dcnt == CNT_W'(HDR_BYTES - 1))
                || (pay_idx + 1'b1 == CNT_W'(pop_len)));
    byte0_len    = len_of(rdata);
    pop_free_sum = SUM_W'(free_cnt) + SUM_W'(byte0_len) + SUM_W'(HDR_BYTES);
  end

  // Output word to load
  always_comb begin
    load     = 1'b0;
    l_status = STAT_OK;
    l_link   = '0;
    l_handle = '0;
    l_len    = '0;
    l_byte   = '0;
    l_bvalid = 1'b0;
    if (is_hdr) begin
      load     = 1'b1;
      l_status = reject ? STAT_REJECT : STAT_OK;
    end else if (is_pop && (pkt_cnt == '0)) begin
      load     = 1'b1;
      l_status = STAT_EMPTY;
    end else if (move && pop_out) begin
      load     = 1'b1;
      l_status = STAT_DATA;
      l_link   = pop_link;
      if (dcnt == CNT_W'(HDR_BYTES - 1)) begin
        l_handle = {pop_hi, rdata};
      end else begin
        l_handle = {pop_hi, pop_lo};
        l_len    = pop_len;
        l_byte   = rdata;
        l_bvalid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      ring[waddr] <= wdata;
    end
    if (issue) begin
      rdata <= ring[rp];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      wp       <= '0;
      rp       <= '0;
      rs       <= '0;
      free_cnt <= FREE_W'(BUF_BYTES);
      pkt_cnt  <= '0;
      pending  <= '0;
      hcnt     <= '0;
      rcnt     <= '0;
      dcnt     <= '0;
      pend     <= 1'b0;
      ovalid   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (is_hdr) begin
            // Abandon happens even when the new header is then rejected
            if (reject) begin
              wp       <= wp_eff;
              free_cnt <= free_eff;
              pending  <= '0;
            end else begin
              rs       <= wp_eff;
              wp       <= ptr_inc(wp_eff);
              free_cnt <= free_eff - FREE_W'(rec_bytes);
              pending  <= req.payload_length;
              hcnt     <= 2'd1;
              state    <= S_HDR;
              if (req.payload_length == '0) begin
                pkt_cnt <= pkt_cnt + 1'b1;
              end
            end
          end else if (is_byte && abandon) begin
            wp      <= ptr_inc(wp);
            pending <= pending - 1'b1;
            if (pending == LEN_W'(1)) begin
              pkt_cnt <= pkt_cnt + 1'b1;
            end
          end else if (is_pop && (pkt_cnt != '0)) begin
            pkt_cnt <= pkt_cnt - 1'b1;
            rcnt    <= '0;
            dcnt    <= '0;
            pend    <= 1'b0;
            state   <= S_POP;
          end
        end
        S_HDR: begin
          wp   <= ptr_inc(wp);
          hcnt <= hcnt + 1'b1;
          if (hcnt == 2'd3) begin
            state <= S_IDLE;
          end
        end
        S_POP: begin
          if (issue) begin
            rp   <= ptr_inc(rp);
            rcnt <= rcnt + 1'b1;
          end
          if (issue) begin
            pend <= 1'b1;
          end else if (move) begin
            pend <= 1'b0;
          end
          if (move) begin
            dcnt <= dcnt + 1'b1;
            if (dcnt == '0) begin
              // Release the record's space as soon as its length is known
              if (pop_free_sum > SUM_W'(BUF_BYTES)) begin
                free_cnt <= FREE_W'(BUF_BYTES);
              end else begin
                free_cnt <= pop_free_sum[FREE_W-1:0];
              end
            end
          end
          if (pop_done) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (load) begin
        ovalid <= 1'b1;
      end else if (rsp.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  // Capture the incoming header, the popped record header and the output word
  always_ff @(posedge clk) begin
    if (is_hdr) begin
      hdr_link   <= req.link_id;
      hdr_handle <= req.attr_handle;
    end
    if (move) begin
      case (dcnt)
        CNT_W'(0): pop_len  <= len_of(rdata);
        CNT_W'(1): pop_link <= rdata;
        CNT_W'(2): pop_hi   <= rdata;
        CNT_W'(3): pop_lo   <= rdata;
        default:   ;
      endcase
    end
    if (load) begin
      o_status <= l_status;
      o_link   <= l_link;
      o_handle <= l_handle;
      o_len    <= l_len;
      o_byte   <= l_byte;
      o_bvalid <= l_bvalid;
      // Every word is last except payload bytes before the final one
      o_last   <= !(move && pop_out && !pop_done);
    end
  end

  assign rsp.valid       = ovalid;
  assign rsp.status      = o_status;
  assign rsp.out_link_id = o_link;
  assign rsp.out_handle  = o_handle;
  assign rsp.out_length  = o_len;
  assign rsp.out_byte    = o_byte;
  assign rsp.byte_valid  = o_bvalid;
  assign rsp.last        = o_last;

endmodule

// File: verif/length_prefixed_packet_ring_queue_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// length_prefixed_packet_ring_queue_core_test
// Self-checking bench for the packet ring queue. A mirror of the byte ring
// predicts every status and packet data word from the accepted request
// words. Stimulus is a short directed pass over the corner cases, then
// random packet traffic that fills and drains the ring. The request side
// runs in bursts and the response side stalls on its own pattern.
// ----------------------------------------------------------------------------
module length_prefixed_packet_ring_queue_core_test;
  import lprq_pkg::*;

  // Action code that the block has no use for; it must be dropped silently
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 205;  // counted words that do real work
  localparam int HOLD_CYCLES  = 300;  // one long response stall
  localparam int IDLE_LIMIT   = 4000; // cycles with no word moving on either side
  localparam int DRAIN_CYCLES = 16;   // header write-back plus margin

  typedef struct packed {
    logic [ACT_W-1:0]    action;
    logic [LINK_W-1:0]   link_id;
    logic [HANDLE_W-1:0] attr_handle;
    logic [LEN_W-1:0]    payload_length;
    logic [BYTE_W-1:0]   payload_byte;
  } req_word_t;

  localparam int REQ_W = $bits(req_word_t);

  typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic [LINK_W-1:0]   link_id;
    logic [HANDLE_W-1:0] handle;
    logic [LEN_W-1:0]    length;
    logic [BYTE_W-1:0]   data;
    logic                byte_valid;
    logic                last;
  } rsp_word_t;

  typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_SPARSE} rx_mode_t;

  // --------------------------------------------------------------------------
  // Ring mirror: holds its own copy of the ring and its pointers, turns each
  // accepted request word into the response words it owes, and matches them
  // against what the block sends.
  // --------------------------------------------------------------------------
  class packet_ring_mirror;
    rsp_word_t   owed_words[$];
    logic [7:0]  ring_bytes [BUF_BYTES];
    int unsigned wr_ptr, rd_ptr, free_bytes, owed_payload, record_start;
    logic [7:0]  packets_held;
    int unsigned errors, words_matched;
    int unsigned headers_ok, headers_rejected, space_rejects, abandoned;
    int unsigned packets_popped, empty_pops;

    function new();
      wr_ptr = 0;
      rd_ptr = 0;
      free_bytes = BUF_BYTES;
      owed_payload = 0;
      record_start = 0;
      packets_held = 0;
      errors = 0;
      words_matched = 0;
      headers_ok = 0;
      headers_rejected = 0;
      space_rejects = 0;
      abandoned = 0;
      packets_popped = 0;
      empty_pops = 0;
    endfunction

    function void put_byte(logic [7:0] b);
      ring_bytes[wr_ptr] = b;
      wr_ptr = (wr_ptr + 1) % BUF_BYTES;
    endfunction

    function logic [7:0] take_byte();
      logic [7:0] b;
      b = ring_bytes[rd_ptr];
      rd_ptr = (rd_ptr + 1) % BUF_BYTES;
      return b;
    endfunction

    function void owe(logic [STAT_W-1:0] st, logic [LINK_W-1:0] lk,
                      logic [HANDLE_W-1:0] hd, logic [LEN_W-1:0] ln,
                      logic [BYTE_W-1:0] db, logic bv, logic lst);
      rsp_word_t w;
      w.status = st;
      w.link_id = lk;
      w.handle = hd;
      w.length = ln;
      w.data = db;
      w.byte_valid = bv;
      w.last = lst;
      owed_words.push_back(w);
    endfunction

    // Advance the mirror by one accepted request word
    function void take_request(req_word_t w);
      int unsigned written, plen, stored, len, i;
      logic [LINK_W-1:0]   plink;
      logic [HANDLE_W-1:0] phandle;
      plen = int'(w.payload_length);
      case (w.action)
        ACT_HEADER: begin
          // Abandon an unfinished record: hand back its whole reservation
          if (owed_payload != 0) begin
            written = (wr_ptr + BUF_BYTES - record_start) % BUF_BYTES;
            free_bytes += written + owed_payload;
            if (free_bytes > BUF_BYTES) free_bytes = BUF_BYTES;
            wr_ptr = record_start;
            owed_payload = 0;
            abandoned++;
          end
          if (plen > MAX_PAYLOAD || free_bytes < plen + HDR_BYTES) begin
            if (plen <= MAX_PAYLOAD) space_rejects++;
            headers_rejected++;
            owe(STAT_REJECT, '0, '0, '0, '0, 1'b0, 1'b1);
          end else begin
            record_start = wr_ptr;
            put_byte(8'(plen + HDR_BYTES));
            put_byte(w.link_id);
            put_byte(w.attr_handle[15:8]);
            put_byte(w.attr_handle[7:0]);
            free_bytes -= plen + HDR_BYTES;
            owed_payload = plen;
            if (plen == 0) packets_held++;
            headers_ok++;
            owe(STAT_OK, '0, '0, '0, '0, 1'b0, 1'b1);
          end
        end
        ACT_BYTE: begin
          // Drop bytes with no open record or past the declared length
          if (owed_payload != 0) begin
            put_byte(w.payload_byte);
            owed_payload--;
            if (owed_payload == 0) packets_held++;
          end
        end
        ACT_POP: begin
          if (packets_held == 0) begin
            empty_pops++;
            owe(STAT_EMPTY, '0, '0, '0, '0, 1'b0, 1'b1);
          end else begin
            stored = int'(take_byte());
            len = (stored >= HDR_BYTES) ? stored - HDR_BYTES : 0;
            if (len > MAX_PAYLOAD) len = MAX_PAYLOAD;
            plink = take_byte();
            phandle[15:8] = take_byte();
            phandle[7:0] = take_byte();
            free_bytes += len + HDR_BYTES;
            if (free_bytes > BUF_BYTES) free_bytes = BUF_BYTES;
            packets_held--;
            packets_popped++;
            if (len == 0) begin
              owe(STAT_DATA, plink, phandle, '0, '0, 1'b0, 1'b1);
            end else begin
              for (i = 0; i < len; i++) begin
                owe(STAT_DATA, plink, phandle, LEN_W'(len), take_byte(), 1'b1,
                    (i + 1 == len));
              end
            end
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (got_v !== exp_v) begin
        $error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
        errors++;
      end
    endfunction

    // Compare one response word with the oldest owed one
    function void match_response(rsp_word_t got);
      rsp_word_t want;
      if (owed_words.size() == 0) begin
        $error("response word with nothing owed: status %0h", got.status);
        errors++;
        return;
      end
      want = owed_words.pop_front();
      check_field("status", want.status, got.status);
      check_field("out_link_id", want.link_id, got.link_id);
      check_field("out_handle", want.handle, got.handle);
      check_field("out_length", want.length, got.length);
      check_field("out_byte", want.data, got.data);
      check_field("byte_valid", want.byte_valid, got.byte_valid);
      check_field("last", want.last, got.last);
      words_matched++;
    endfunction
  endclass

  logic clk;
  logic rst;
  logic hold_req;
  int unsigned burst_left;
  packet_ring_mirror mirror;

  lprq_req_if req_ch ();
  lprq_rsp_if rsp_ch ();

  length_prefixed_packet_ring_queue_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Monitor: sample both channels at the edge. Check responses before noting
  // the request of the same edge; a response can never belong to a request
  // taken at the same edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        mirror.match_response({rsp_ch.status, rsp_ch.out_link_id, rsp_ch.out_handle,
                               rsp_ch.out_length, rsp_ch.out_byte, rsp_ch.byte_valid,
                               rsp_ch.last});
      end
      if (req_ch.valid && req_ch.ready) begin
        mirror.take_request({req_ch.action, req_ch.link_id, req_ch.attr_handle,
                             req_ch.payload_length, req_ch.payload_byte});
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when no word moves on either side for too long.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("length_prefixed_packet_ring_queue_core regression: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Response side: pick a stall pattern for a random stretch, then another.
  // Once the stimulus asks for it, hold ready low for one long stretch so the
  // block backs up and stalls its request side. Assign ready once per edge.
  // --------------------------------------------------------------------------
  initial begin
    rx_mode_t    mode;
    int unsigned mode_left, hold_left;
    bit          hold_taken, ready_next;
    mode = RX_STREAM;
    mode_left = 0;
    hold_left = 0;
    hold_taken = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_left = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (rst) begin
        ready_next = 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(5, 60);
        end
        mode_left--;
        case (mode)
          RX_STREAM: ready_next = 1'b1;
          RX_COIN:   ready_next = 1'($urandom_range(0, 1));
          default:   ready_next = ($urandom_range(0, 5) == 0);
        endcase
      end
      rsp_ch.ready <= ready_next;
    end
  end

  // --------------------------------------------------------------------------
  // Request side drivers
  // --------------------------------------------------------------------------

  // Present one word and hold it until the block takes it
  task automatic offer(input req_word_t w);
    req_ch.valid          <= 1'b1;
    req_ch.action         <= w.action;
    req_ch.link_id        <= w.link_id;
    req_ch.attr_handle    <= w.attr_handle;
    req_ch.payload_length <= w.payload_length;
    req_ch.payload_byte   <= w.payload_byte;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
  endtask

  // Count down the current burst; between bursts usually drop valid for a random gap
  task automatic pace();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        req_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  function automatic req_word_t random_word(logic [ACT_W-1:0] act);
    req_word_t w;
    w = REQ_W'({$urandom, $urandom});
    w.action = act;
    return w;
  endfunction

  function automatic req_word_t make_word(logic [ACT_W-1:0] act, logic [LINK_W-1:0] lk,
                                          logic [HANDLE_W-1:0] hd, logic [LEN_W-1:0] ln,
                                          logic [BYTE_W-1:0] db);
    return {act, lk, hd, ln, db};
  endfunction

  // Send a header and n_bytes payload words; a short count leaves the record
  // open for the next header to abandon. Now and then slip in a pop mid-record
  // and a stray byte past the end. Return the number of working words sent.
  task automatic send_packet(input int unsigned plen, input int unsigned n_bytes,
                             input bit stray_tail, output int unsigned sent);
    req_word_t w;
    w = random_word(ACT_HEADER);
    w.payload_length = LEN_W'(plen);
    offer(w);
    pace();
    sent = 1;
    for (int unsigned i = 0; i < n_bytes; i++) begin
      if ($urandom_range(0, 14) == 0) begin
        offer(random_word(ACT_POP));
        pace();
        sent++;
      end
      offer(random_word(ACT_BYTE));
      pace();
      sent++;
    end
    if (stray_tail) begin
      offer(random_word(ACT_BYTE));
      pace();
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned real_items, pick, pop_share, plen, n_bytes, sent, rejects_mark;
    bit          filling;
    req_word_t   w;

    rst = 1'b1;
    hold_req = 1'b0;
    burst_left = 0;
    mirror = new();
    req_ch.valid = 1'b0;
    req_ch.action = ACT_HEADER;
    req_ch.link_id = '0;
    req_ch.attr_handle = '0;
    req_ch.payload_length = '0;
    req_ch.payload_byte = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed pass: empty pop, dropped words, zero-length packet at the
    // extremes, oversize headers, stray tail byte, pop during an open
    // record, abandon by a new header.
    offer(make_word(ACT_POP, 8'h00, 16'h0000, 5'd0, 8'h00));
    offer(make_word(ACT_BYTE, 8'h00, 16'h0000, 5'd0, 8'hC3));
    offer(make_word(ACT_UNUSED, 8'hFF, 16'hFFFF, 5'd31, 8'hFF));
    offer(make_word(ACT_HEADER, 8'hFF, 16'hFFFF, 5'd0, 8'h00));
    offer(make_word(ACT_POP, 8'h00, 16'h0000, 5'd0, 8'h00));
    offer(make_word(ACT_HEADER, 8'hA5, 16'h8001, 5'd3, 8'h00));
    offer(make_word(ACT_BYTE, 8'h00, 16'h0000, 5'd0, 8'h00));
    offer(make_word(ACT_BYTE, 8'h00, 16'h0000, 5'd0, 8'hFF));
    offer(make_word(ACT_BYTE, 8'h00, 16'h0000, 5'd0, 8'h5A));
    offer(make_word(ACT_BYTE, 8'h00, 16'h0000, 5'd0, 8'h77));
    offer(make_word(ACT_HEADER, 8'h11, 16'h2222, 5'd21, 8'h00));
    offer(make_word(ACT_HEADER, 8'h11, 16'h2222, 5'd31, 8'h00));
    offer(make_word(ACT_HEADER, 8'h5A, 16'h7FFE, 5'd2, 8'h00));
    offer(make_word(ACT_BYTE, 8'h00, 16'h0000, 5'd0, 8'h81));
    offer(make_word(ACT_POP, 8'h00, 16'h0000, 5'd0, 8'h00));
    offer(make_word(ACT_HEADER, 8'h00, 16'h0000, 5'd1, 8'h00));
    offer(make_word(ACT_BYTE, 8'h00, 16'h0000, 5'd0, 8'h3C));
    offer(make_word(ACT_POP, 8'h00, 16'h0000, 5'd0, 8'h00));
    offer(make_word(ACT_POP, 8'h00, 16'h0000, 5'd0, 8'h00));
    offer(make_word(ACT_HEADER, 8'h00, 16'hFFFF, 5'd20, 8'h00));
    offer(make_word(ACT_POP, 8'h00, 16'h0000, 5'd0, 8'h00));
    pace();

    // Random traffic: alternate between filling the ring until it turns away
    // headers for space and draining it empty.
    real_items = 0;
    filling = 1'b1;
    rejects_mark = mirror.space_rejects;
    while (real_items < RANDOM_ITEMS) begin
      if (real_items >= 60 && !hold_req) hold_req <= 1'b1;
      if (filling && mirror.space_rejects >= rejects_mark + 2) begin
        filling = 1'b0;
      end else if (!filling && mirror.packets_held == 0) begin
        filling = 1'b1;
        rejects_mark = mirror.space_rejects;
      end
      pop_share = filling ? 6 : 60;
      pick = $urandom_range(0, 99);
      if (pick < pop_share) begin
        offer(random_word(ACT_POP));
        pace();
        real_items++;
      end else if (pick < pop_share + 6) begin
        // Noise: unused action or a loose byte
        offer(random_word(($urandom_range(0, 1) != 0) ? ACT_UNUSED : ACT_BYTE));
        pace();
      end else if (pick < pop_share + 10) begin
        w = random_word(ACT_HEADER);
        w.payload_length = LEN_W'($urandom_range(MAX_PAYLOAD + 1, 31));
        offer(w);
        pace();
        real_items++;
      end else begin
        pick = $urandom_range(0, 19);
        if (pick < 12) plen = $urandom_range(0, 4);
        else if (pick < 16) plen = $urandom_range(5, MAX_PAYLOAD - 1);
        else plen = MAX_PAYLOAD;
        n_bytes = plen;
        if (plen != 0 && $urandom_range(0, 9) == 0) n_bytes = $urandom_range(0, plen - 1);
        send_packet(plen, n_bytes, ($urandom_range(0, 9) == 0), sent);
        real_items += sent;
      end
    end
    req_ch.valid <= 1'b0;

    // Wait out every owed word, then give the block time to send anything extra
    while (mirror.owed_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d headers taken, %0d turned away (%0d for space), %0d abandoned",
             mirror.headers_ok, mirror.headers_rejected, mirror.space_rejects,
             mirror.abandoned);
    $display("popped %0d packets, %0d empty pops, %0d response words matched",
             mirror.packets_popped, mirror.empty_pops, mirror.words_matched);
    if (mirror.errors == 0 && mirror.owed_words.size() == 0) begin
      $display("length_prefixed_packet_ring_queue_core regression: pass");
    end else begin
      $display("length_prefixed_packet_ring_queue_core regression: fail");
    end
    $finish;
  end

endmodule

// File: length_prefixed_packet_ring_queue_core.f
hw/rtl/lprq_pkg.sv
hw/rtl/lprq_req_if.sv
hw/rtl/lprq_rsp_if.sv
hw/rtl/length_prefixed_packet_ring_queue_core.sv
verif/length_prefixed_packet_ring_queue_core_test.sv
